@@ hw/rtl/dtlpm_pkg.sv @@
// Shared types and constants for the decimal digit trie prefix matcher.
`default_nettype none

package dtlpm_pkg;

    localparam int NODE_COUNT_DEF = 65536;
    localparam int MAX_DIGITS_DEF = 32;

    localparam int DIGIT_W   = 6;
    localparam int LEN_W     = 7;
    localparam int CARRIER_W = 16;
    localparam int REF_W     = 17;
    localparam int NODE_W    = 16;
    localparam int SLOT_W    = 4;
    localparam int CHAR_W    = 8;
    localparam int OP_W      = 2;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_WRITE = 2'd0;
    localparam op_t OP_CHAR  = 2'd1;
    localparam op_t OP_EMPTY = 2'd2;

    localparam logic [SLOT_W-1:0] CARRIER_SLOT = 4'd10;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] DIGIT_MAX    = 8'd9;

    typedef struct packed {
        op_t                       op;
        logic [NODE_W-1:0]         node_index;
        logic [SLOT_W-1:0]         slot;
        logic signed [REF_W-1:0]   word_value;
        logic [CHAR_W-1:0]         char_code;
        logic                      last_char;
    } item_t;

    typedef struct packed {
        logic signed [LEN_W-1:0]   match_length;
        logic [CARRIER_W-1:0]      carrier_id;
    } result_t;

    typedef struct packed {
        logic      valid;
        result_t   res;
    } res_push_t;

endpackage

`default_nettype wire

@@ hw/rtl/dtlpm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module dtlpm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dtlpm_outq.sv @@
// Two-entry result queue between the trie walker and the output stream.
`default_nettype none

module dtlpm_outq (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire dtlpm_pkg::res_push_t push,
    output logic                      room,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output dtlpm_pkg::result_t        head
);

    logic [1:0]         cnt_reg;
    logic [1:0]         cnt_next;
    dtlpm_pkg::result_t q0_reg;
    dtlpm_pkg::result_t q0_next;
    dtlpm_pkg::result_t q1_reg;
    dtlpm_pkg::result_t q1_next;
    logic               pop;

    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (cnt_reg != 2'd0);
    assign room     = (cnt_reg != 2'd2);
    assign head     = q0_reg;

    always_comb
    begin
        cnt_next = cnt_reg;
        q0_next  = q0_reg;
        q1_next  = q1_reg;
        if (pop)
        begin
            if (cnt_reg == 2'd2)
            begin
                q0_next = q1_reg;
            end
            else if (push.valid)
            begin
                q0_next = push.res;
            end
        end
        else if (push.valid)
        begin
            if (cnt_reg == 2'd0)
            begin
                q0_next = push.res;
            end
            else
            begin
                q1_next = push.res;
            end
        end
        cnt_next = cnt_reg + {1'b0, push.valid} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

`default_nettype wire

@@ hw/rtl/dtlpm_walker.sv @@
// Trie walk sequencer: node memory writes, per-digit reads and best-match tracking.
`default_nettype none

module dtlpm_walker #(
    parameter int NODE_COUNT = dtlpm_pkg::NODE_COUNT_DEF,
    parameter int MAX_DIGITS = dtlpm_pkg::MAX_DIGITS_DEF,
    localparam int NODE_AW  = $clog2(NODE_COUNT),
    localparam int CHILD_AW = $clog2(NODE_COUNT * 10)
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire dtlpm_pkg::item_t                  item,
    input  wire logic                              room,
    output dtlpm_pkg::res_push_t                   push,
    output logic                                   child_we,
    output logic [CHILD_AW-1:0]                    child_waddr,
    output logic [dtlpm_pkg::REF_W-1:0]            child_wdata,
    output logic                                   child_re,
    output logic [CHILD_AW-1:0]                    child_raddr,
    input  wire logic [dtlpm_pkg::REF_W-1:0]       child_rdata,
    output logic                                   car_we,
    output logic [NODE_AW-1:0]                     car_waddr,
    output logic [dtlpm_pkg::CARRIER_W-1:0]        car_wdata,
    output logic                                   car_re,
    output logic [NODE_AW-1:0]                     car_raddr,
    input  wire logic [dtlpm_pkg::CARRIER_W-1:0]   car_rdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_FIN,
        ST_ROOT
    } state_t;

    state_t                                state_reg, state_next;
    logic [dtlpm_pkg::NODE_W-1:0]          node_reg, node_next;
    logic [dtlpm_pkg::DIGIT_W-1:0]         digits_reg, digits_next;
    logic signed [dtlpm_pkg::LEN_W-1:0]    best_len_reg, best_len_next;
    logic [dtlpm_pkg::CARRIER_W-1:0]       best_car_reg, best_car_next;
    logic                                  stopped_reg, stopped_next;
    logic                                  pend_reg, pend_next;
    logic                                  fresh_reg, fresh_next;
    logic                                  go_reg, go_next;
    logic                                  last_reg, last_next;

    logic                                  accept;
    logic                                  fresh;
    logic                                  go;
    logic [dtlpm_pkg::CHAR_W-1:0]          digit;
    logic signed [dtlpm_pkg::LEN_W-1:0]    eff_len;
    logic [dtlpm_pkg::CARRIER_W-1:0]       eff_car;
    logic signed [dtlpm_pkg::LEN_W-1:0]    root_len;
    logic [dtlpm_pkg::CARRIER_W-1:0]       root_car;
    logic signed [dtlpm_pkg::REF_W-1:0]    cref;
    logic [dtlpm_pkg::REF_W-1:0]           leaf_mag;
    logic [dtlpm_pkg::DIGIT_W-1:0]         digits_inc;
    logic                                  node_ok;
    logic [23:0]                           rd_idx;
    logic [23:0]                           wr_idx;

    assign s_tready = (state_reg == ST_IDLE) && room;
    assign accept   = s_tvalid && s_tready;
    assign digit    = item.char_code - dtlpm_pkg::CHAR_ZERO;
    assign go       = (32'(digits_reg) < MAX_DIGITS) && (digit <= dtlpm_pkg::DIGIT_MAX);
    assign fresh    = !stopped_reg && (digits_reg == '0) && (node_reg == '0)
                      && (best_len_reg < 0) && (best_car_reg == '0);
    assign node_ok  = 32'(item.node_index) < NODE_COUNT;
    assign rd_idx   = {5'd0, node_reg, 3'd0} + {7'd0, node_reg, 1'd0} + {20'd0, digit[3:0]};
    assign wr_idx   = {5'd0, item.node_index, 3'd0} + {7'd0, item.node_index, 1'd0}
                      + {20'd0, item.slot};
    assign cref       = $signed(child_rdata);
    assign leaf_mag   = dtlpm_pkg::REF_W'(-cref);
    assign digits_inc = digits_reg + 1'b1;

    // pending carrier check of the node entered by the previous digit
    always_comb
    begin
        if (pend_reg && (car_rdata != '0))
        begin
            eff_len = $signed({1'b0, digits_reg});
            eff_car = car_rdata;
        end
        else
        begin
            eff_len = best_len_reg;
            eff_car = best_car_reg;
        end
        if (car_rdata != '0)
        begin
            root_len = '0;
            root_car = car_rdata;
        end
        else
        begin
            root_len = -7'sd1;
            root_car = '0;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        node_next     = node_reg;
        digits_next   = digits_reg;
        best_len_next = best_len_reg;
        best_car_next = best_car_reg;
        stopped_next  = stopped_reg;
        pend_next     = pend_reg;
        fresh_next    = fresh_reg;
        go_next       = go_reg;
        last_next     = last_reg;
        push          = '0;
        child_we      = 1'b0;
        child_waddr   = CHILD_AW'(wr_idx);
        child_wdata   = item.word_value;
        child_re      = 1'b0;
        child_raddr   = CHILD_AW'(rd_idx);
        car_we        = 1'b0;
        car_waddr     = NODE_AW'(item.node_index);
        car_wdata     = (item.word_value > 0) ? item.word_value[15:0] : '0;
        car_re        = 1'b0;
        car_raddr     = '0;

        case (state_reg)
            ST_IDLE:
            begin
                best_len_next = eff_len;
                best_car_next = eff_car;
                pend_next     = 1'b0;
                if (accept)
                begin
                    case (item.op)
                        dtlpm_pkg::OP_WRITE:
                        begin
                            if (node_ok && (item.slot < dtlpm_pkg::CARRIER_SLOT))
                            begin
                                child_we = 1'b1;
                            end
                            else if (node_ok && (item.slot == dtlpm_pkg::CARRIER_SLOT))
                            begin
                                car_we = 1'b1;
                            end
                        end
                        dtlpm_pkg::OP_CHAR:
                        begin
                            if (stopped_reg)
                            begin
                                if (item.last_char)
                                begin
                                    push.valid            = 1'b1;
                                    push.res.match_length = eff_len;
                                    push.res.carrier_id   = eff_car;
                                    node_next     = '0;
                                    digits_next   = '0;
                                    best_len_next = -7'sd1;
                                    best_car_next = '0;
                                    stopped_next  = 1'b0;
                                end
                            end
                            else
                            begin
                                child_re   = go;
                                car_re     = fresh;
                                fresh_next = fresh;
                                go_next    = go;
                                last_next  = item.last_char;
                                state_next = ST_STEP;
                            end
                        end
                        dtlpm_pkg::OP_EMPTY:
                        begin
                            car_re     = 1'b1;
                            state_next = ST_ROOT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_STEP:
            begin
                if (fresh_reg)
                begin
                    best_len_next = root_len;
                    best_car_next = root_car;
                end
                if (!go_reg)
                begin
                    stopped_next = 1'b1;
                end
                else if ((cref == '0) || ((cref > 0) && (32'(cref[15:0]) >= NODE_COUNT)))
                begin
                    stopped_next = 1'b1;
                end
                else if (cref < 0)
                begin
                    digits_next   = digits_inc;
                    best_len_next = $signed({1'b0, digits_inc});
                    best_car_next = leaf_mag[16] ? '1 : leaf_mag[15:0];
                    stopped_next  = 1'b1;
                end
                else
                begin
                    digits_next = digits_inc;
                    node_next   = cref[15:0];
                    car_re      = 1'b1;
                    car_raddr   = NODE_AW'(cref[15:0]);
                    pend_next   = 1'b1;
                end
                state_next = last_reg ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                push.valid            = 1'b1;
                push.res.match_length = eff_len;
                push.res.carrier_id   = eff_car;
                node_next     = '0;
                digits_next   = '0;
                best_len_next = -7'sd1;
                best_car_next = '0;
                stopped_next  = 1'b0;
                pend_next     = 1'b0;
                state_next    = ST_IDLE;
            end
            ST_ROOT:
            begin
                push.valid            = 1'b1;
                push.res.match_length = root_len;
                push.res.carrier_id   = root_car;
                node_next     = '0;
                digits_next   = '0;
                best_len_next = -7'sd1;
                best_car_next = '0;
                stopped_next  = 1'b0;
                pend_next     = 1'b0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            node_reg     <= '0;
            digits_reg   <= '0;
            best_len_reg <= -7'sd1;
            best_car_reg <= '0;
            stopped_reg  <= 1'b0;
            pend_reg     <= 1'b0;
            fresh_reg    <= 1'b0;
            go_reg       <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            node_reg     <= node_next;
            digits_reg   <= digits_next;
            best_len_reg <= best_len_next;
            best_car_reg <= best_car_next;
            stopped_reg  <= stopped_next;
            pend_reg     <= pend_next;
            fresh_reg    <= fresh_next;
            go_reg       <= go_next;
            last_reg     <= last_next;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/digit_trie_longest_prefix_match_top.sv @@
// Top level of the decimal digit trie longest-prefix matcher.
`default_nettype none

// Node words are loaded by write transactions into two RAMs, each with one
// write port and one read port with registered read data: ten child
// references per node and one carrier per node. Neither RAM is cleared
// after reset; an entry must be written before a walk reads it. In a live
// walk a number character issues the child read, then examines it and issues
// the next node's carrier read, checked while the next character is taken;
// an ended walk consumes a character without a read. A live walk's last
// character then pushes its result; an empty-number lookup reads the root
// carrier, then pushes it. Each digit needs the node reached by the one
// before. Up to two results are held at the output.
module digit_trie_longest_prefix_match_top #(
    parameter int NODE_COUNT = dtlpm_pkg::NODE_COUNT_DEF,
    parameter int MAX_DIGITS = dtlpm_pkg::MAX_DIGITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // node_index[15:0], slot[19:16], word_value[36:20], char_code[44:37]
    input  wire logic [47:0] s_tdata,
    // op[1:0]
    input  wire logic [1:0]  s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // match_length[6:0], carrier_id[22:7]
    output logic [23:0]      m_tdata
);

    localparam int NODE_AW     = $clog2(NODE_COUNT);
    localparam int CHILD_DEPTH = NODE_COUNT * 10;
    localparam int CHILD_AW    = $clog2(CHILD_DEPTH);

    dtlpm_pkg::item_t                   item;
    dtlpm_pkg::res_push_t               push;
    dtlpm_pkg::result_t                 head;
    logic                               room;
    logic                               child_we;
    logic [CHILD_AW-1:0]                child_waddr;
    logic [dtlpm_pkg::REF_W-1:0]        child_wdata;
    logic                               child_re;
    logic [CHILD_AW-1:0]                child_raddr;
    logic [dtlpm_pkg::REF_W-1:0]        child_rdata;
    logic                               car_we;
    logic [NODE_AW-1:0]                 car_waddr;
    logic [dtlpm_pkg::CARRIER_W-1:0]    car_wdata;
    logic                               car_re;
    logic [NODE_AW-1:0]                 car_raddr;
    logic [dtlpm_pkg::CARRIER_W-1:0]    car_rdata;

    assign item.op         = s_tuser;
    assign item.node_index = s_tdata[15:0];
    assign item.slot       = s_tdata[19:16];
    assign item.word_value = $signed(s_tdata[36:20]);
    assign item.char_code  = s_tdata[44:37];
    assign item.last_char  = s_tlast;

    assign m_tdata = {1'b0, head.carrier_id, head.match_length};

    dtlpm_walker #(
        .NODE_COUNT (NODE_COUNT),
        .MAX_DIGITS (MAX_DIGITS)
    ) u_walker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .item        (item),
        .room        (room),
        .push        (push),
        .child_we    (child_we),
        .child_waddr (child_waddr),
        .child_wdata (child_wdata),
        .child_re    (child_re),
        .child_raddr (child_raddr),
        .child_rdata (child_rdata),
        .car_we      (car_we),
        .car_waddr   (car_waddr),
        .car_wdata   (car_wdata),
        .car_re      (car_re),
        .car_raddr   (car_raddr),
        .car_rdata   (car_rdata)
    );

    dtlpm_ram #(
        .WIDTH (dtlpm_pkg::REF_W),
        .DEPTH (CHILD_DEPTH)
    ) u_child_ram (
        .clk   (clk),
        .we    (child_we),
        .waddr (child_waddr),
        .wdata (child_wdata),
        .re    (child_re),
        .raddr (child_raddr),
        .rdata (child_rdata)
    );

    dtlpm_ram #(
        .WIDTH (dtlpm_pkg::CARRIER_W),
        .DEPTH (NODE_COUNT)
    ) u_carrier_ram (
        .clk   (clk),
        .we    (car_we),
        .waddr (car_waddr),
        .wdata (car_wdata),
        .re    (car_re),
        .raddr (car_raddr),
        .rdata (car_rdata)
    );

    dtlpm_outq u_outq (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .room     (room),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .head     (head)
    );

endmodule

`default_nettype wire
